// ===== sv/sorted_linked_list_pool_macros.svh =====
// Assertion helpers for the sorted list pool.
`ifndef SORTED_LINKED_LIST_POOL_MACROS_SVH
`define SORTED_LINKED_LIST_POOL_MACROS_SVH

// Check that a condition implies another one in the same cycle.
`define SLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the next cycle.
`define SLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/slp_pkg.sv =====
package slp_pkg;

  localparam int DEF_POOL_SLOTS = 16;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] key;
    logic signed [31:0] info;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot;
    logic signed [31:0] found_info;
    logic [4:0]         entry_count;
  } out_word_t;

  // memory port controls from the sequencer
  typedef struct packed {
    logic rd_en;
    logic we_row;
    logic we_link;
  } mem_ctl_t;

endpackage

// ===== sv/slp_mem.sv =====
module slp_mem #(
  parameter int POOL_SLOTS = slp_pkg::DEF_POOL_SLOTS
) (
  input  logic                                 clk,
  input  slp_pkg::mem_ctl_t                    ctl,
  input  logic [$clog2(POOL_SLOTS)-1:0]        rd_addr,
  input  logic [$clog2(POOL_SLOTS)-1:0]        wr_addr,
  input  logic signed [31:0]                   wr_key,
  input  logic signed [31:0]                   wr_info,
  input  logic [$clog2(POOL_SLOTS+1)-1:0]      wr_link,
  output logic signed [31:0]                   rd_key,
  output logic signed [31:0]                   rd_info,
  output logic [$clog2(POOL_SLOTS+1)-1:0]      rd_link
);

  localparam int LINK_W = $clog2(POOL_SLOTS + 1);

  logic signed [31:0] key_mem  [POOL_SLOTS];
  logic signed [31:0] info_mem [POOL_SLOTS];
  logic [LINK_W-1:0]  link_mem [POOL_SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_info <= info_mem[rd_addr];
      rd_link <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we_row) begin
      key_mem[wr_addr]  <= wr_key;
      info_mem[wr_addr] <= wr_info;
    end
    if (ctl.we_link) begin
      link_mem[wr_addr] <= wr_link;
    end
  end

endmodule

// ===== sv/slp_ctrl.sv =====
module slp_ctrl #(
  parameter int POOL_SLOTS = slp_pkg::DEF_POOL_SLOTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  slp_pkg::in_word_t                    in_data,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output slp_pkg::out_word_t                   res_word,
  output slp_pkg::mem_ctl_t                    mem_ctl,
  output logic [$clog2(POOL_SLOTS)-1:0]        rd_addr,
  output logic [$clog2(POOL_SLOTS)-1:0]        wr_addr,
  output logic signed [31:0]                   wr_key,
  output logic signed [31:0]                   wr_info,
  output logic [$clog2(POOL_SLOTS+1)-1:0]      wr_link,
  input  logic signed [31:0]                   rd_key,
  input  logic signed [31:0]                   rd_info,
  input  logic [$clog2(POOL_SLOTS+1)-1:0]      rd_link
);

  localparam int SLOT_W = $clog2(POOL_SLOTS);
  localparam int LINK_W = $clog2(POOL_SLOTS + 1);
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FREE = 6'b000010,
    S_WALK = 6'b000100,
    S_ROW  = 6'b001000,
    S_LINK = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] info_r, info_nxt;
  logic [LINK_W-1:0]  free_head_r, free_head_nxt;
  logic [LINK_W-1:0]  used_head_r, used_head_nxt;
  logic [LINK_W-1:0]  count_r, count_nxt;
  logic [LINK_W-1:0]  fill_r, fill_nxt;
  logic [LINK_W-1:0]  prev_r, prev_nxt;
  logic [LINK_W-1:0]  cur_r, cur_nxt;
  logic [LINK_W-1:0]  free_next_r, free_next_nxt;
  logic [LINK_W-1:0]  succ_r, succ_nxt;
  logic [LINK_W-1:0]  slot_r, slot_nxt;
  logic [1:0]         status_r, status_nxt;
  logic signed [31:0] res_info_r, res_info_nxt;

  logic               is_insert;
  logic               key_lt;
  logic [LINK_W-1:0]  free_link;

  assign is_insert = (mode_r == slp_pkg::MODE_INSERT);
  assign key_lt    = ($signed(rd_key) < $signed(key_r));
  // slots at or above the fill mark were never written: they chain to the next slot
  assign free_link = (free_head_r >= fill_r) ? (free_head_r + LINK_W'(1)) : rd_link;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  assign res_word.status      = status_r;
  assign res_word.slot        = 4'(slot_r);
  assign res_word.found_info  = res_info_r;
  assign res_word.entry_count = 5'(count_r);

  assign wr_addr = (state_r == S_ROW) ?
                   (is_insert ? free_head_r[SLOT_W-1:0] : cur_r[SLOT_W-1:0]) :
                   prev_r[SLOT_W-1:0];
  assign wr_key  = key_r;
  assign wr_info = info_r;
  assign wr_link = (state_r == S_ROW) ? (is_insert ? cur_r : free_head_r) :
                                        (is_insert ? slot_r : succ_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    info_nxt      = info_r;
    free_head_nxt = free_head_r;
    used_head_nxt = used_head_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    free_next_nxt = free_next_r;
    succ_nxt      = succ_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    res_info_nxt  = res_info_r;
    mem_ctl       = '0;
    rd_addr       = used_head_r[SLOT_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt     = in_data.mode;
          key_nxt      = in_data.key;
          info_nxt     = in_data.info;
          slot_nxt     = '0;
          res_info_nxt = '0;
          status_nxt   = slp_pkg::ST_OK;
          prev_nxt     = END_MARK;
          case (in_data.mode)
            slp_pkg::MODE_INSERT: begin
              if (free_head_r == END_MARK) begin
                status_nxt = slp_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = free_head_r[SLOT_W-1:0];
                state_nxt     = S_FREE;
              end
            end
            slp_pkg::MODE_REMOVE, slp_pkg::MODE_FIND: begin
              if (used_head_r == END_MARK) begin
                status_nxt = slp_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                mem_ctl.rd_en = 1'b1;
                cur_nxt       = used_head_r;
                state_nxt     = S_WALK;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_FREE: begin
        free_next_nxt = free_link;
        cur_nxt       = used_head_r;
        if (used_head_r == END_MARK) begin
          state_nxt = S_ROW;
        end else begin
          mem_ctl.rd_en = 1'b1;
          state_nxt     = S_WALK;
        end
      end

      S_WALK: begin
        if (key_lt) begin
          // advance one link
          prev_nxt = cur_r;
          cur_nxt  = rd_link;
          if (rd_link == END_MARK) begin
            if (is_insert) begin
              state_nxt = S_ROW;
            end else begin
              status_nxt = slp_pkg::ST_NOT_FOUND;
              state_nxt  = S_DONE;
            end
          end else begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = rd_link[SLOT_W-1:0];
          end
        end else if (is_insert) begin
          state_nxt = S_ROW;
        end else if (rd_key != key_r) begin
          status_nxt = slp_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          slot_nxt     = cur_r;
          res_info_nxt = rd_info;
          succ_nxt     = rd_link;
          state_nxt    = (mode_r == slp_pkg::MODE_REMOVE) ? S_ROW : S_DONE;
        end
      end

      S_ROW: begin
        mem_ctl.we_link = 1'b1;
        if (is_insert) begin
          mem_ctl.we_row = 1'b1;
          slot_nxt       = free_head_r;
          free_head_nxt  = free_next_r;
          count_nxt      = count_r + LINK_W'(1);
          if (free_head_r == fill_r) begin
            fill_nxt = fill_r + LINK_W'(1);
          end
          if (prev_r == END_MARK) begin
            used_head_nxt = free_head_r;
          end
        end else begin
          free_head_nxt = cur_r;
          count_nxt     = count_r - LINK_W'(1);
          if (prev_r == END_MARK) begin
            used_head_nxt = succ_r;
          end
        end
        state_nxt = (prev_r == END_MARK) ? S_DONE : S_LINK;
      end

      S_LINK: begin
        mem_ctl.we_link = 1'b1;
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      used_head_r <= END_MARK;
      count_r     <= '0;
      fill_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      used_head_r <= used_head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
    info_r      <= info_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    free_next_r <= free_next_nxt;
    succ_r      <= succ_nxt;
    slot_r      <= slot_nxt;
    status_r    <= status_nxt;
    res_info_r  <= res_info_nxt;
  end

endmodule

// ===== sv/sorted_linked_list_pool.sv =====
// Mode 3, full and empty words go straight to the result; find, remove and insert walk the
//   sorted list one link per cycle through the read port, insert after a pop of the free
//   list, and remove and insert then write back links, an insert also its record row.
// One word is handled at a time: a new word is taken only while the sequencer is idle.
// Reset: rst_n synchronous, active low; the list is empty, every slot is free and no
//   memory clearing pass is needed, so a word is taken in the first cycle after reset.
`include "sorted_linked_list_pool_macros.svh"

module sorted_linked_list_pool #(
  parameter int POOL_SLOTS = slp_pkg::DEF_POOL_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output slp_pkg::out_word_t out_data
);

  localparam int SLOT_W = $clog2(POOL_SLOTS);
  localparam int LINK_W = $clog2(POOL_SLOTS + 1);

  // Slot memory: key, info and link rows. One read port with registered data,
  // one write port with separate enables for the record row and the link field.
  slp_pkg::mem_ctl_t  mem_ctl;
  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  wr_addr;
  logic signed [31:0] wr_key;
  logic signed [31:0] wr_info;
  logic [LINK_W-1:0]  wr_link;
  logic signed [31:0] rd_key;
  logic signed [31:0] rd_info;
  logic [LINK_W-1:0]  rd_link;

  // Finished word from the sequencer, waiting for the output register.
  logic               res_valid;
  logic               res_ready;
  slp_pkg::out_word_t res_word;

  logic               out_valid_r;
  slp_pkg::out_word_t out_word_r;

  // The sequencer does the whole request: pop of the free list for an insert, the
  // walk down the sorted list one link per cycle, then any write-back. All writes
  // of a word land before the next word can issue its first read, so no two
  // accesses to the same slot overlap and no forwarding path is needed.
  slp_ctrl #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_info   (wr_info),
    .wr_link   (wr_link),
    .rd_key    (rd_key),
    .rd_info   (rd_info),
    .rd_link   (rd_link)
  );

  slp_mem #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_info (wr_info),
    .wr_link (wr_link),
    .rd_key  (rd_key),
    .rd_info (rd_info),
    .rd_link (rd_link)
  );

  // Output register: hold the finished word here so the sequencer is free to take
  // the next request while the consumer stalls.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // A full pool reports every slot in use; an empty list reports no records.
  `SLP_ASSERT_IMP(a_full_count,
    out_valid && out_data.status == slp_pkg::ST_FULL,
    out_data.entry_count == 5'(POOL_SLOTS),
    "full status with a count below the pool size")
  `SLP_ASSERT_IMP(a_empty_count,
    out_valid && out_data.status == slp_pkg::ST_EMPTY,
    out_data.entry_count == 5'd0,
    "empty status with records still counted")
  // Failed requests carry no slot and no info.
  `SLP_ASSERT_IMP(a_fail_clean,
    out_valid && out_data.status != slp_pkg::ST_OK,
    out_data.slot == 4'd0 && out_data.found_info == 32'sd0,
    "failed request with slot or info set")
  // A word handed to the output register shows up there in the next cycle.
  `SLP_ASSERT_NXT(a_res_load,
    res_valid && res_ready,
    out_valid,
    "finished word lost on its way to the output")

endmodule
